@@ rtl/twr_pkg.sv @@
// Shared types, constants and table helpers for the Tukey window oscillator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package twr_pkg;

  localparam int FREQ_W     = 23;
  localparam int GAIN_W     = 16;
  localparam int TAPER_W    = 17;
  localparam int RATE_W     = 21;
  localparam int PHASE_W    = 32;
  localparam int WIN_W      = 16;
  localparam int PROD_W     = FREQ_W + RATE_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 21;

  localparam int COS_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam logic [TAPER_W-1:0] TAPER_RESET = TAPER_W'(32768);
  localparam logic [TAPER_W-1:0] TAPER_ONE   = TAPER_W'(65536);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(178957);
  localparam logic [WIN_W-1:0]   WIN_ONE     = WIN_W'(32768);

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPER_RATIO = 4'd0,
    REG_RATE_SCALE  = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_STEP,
    ST_PHASE,
    ST_DIV,
    ST_ROM,
    ST_MUL,
    ST_FIN
  } state_t;

  // Floor quotient by shift and subtract; only used while building constant tables.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned rm;
    q  = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = (rm << 1) | ((num >> b) & 64'd1);
      if (rm >= den) begin
        rm = rm - den;
        q  = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // cos(y) for y in [0, pi/2], Q2.30, Taylor series through the y^20 term, clamped to [0, 1.0].
  function automatic longint unsigned cos_quadrant(input longint unsigned y);
    longint unsigned y2;
    longint unsigned t;
    longint unsigned term;
    longint unsigned dv;
    longint          sum;
    y2   = (y * y) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 1; n <= 10; n++) begin
      t    = (term * y2) >> 30;
      dv   = 64'((2 * n - 1) * (2 * n));
      term = udiv64(t, dv);
      if ((n & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return longint'(sum);
  endfunction

  // Raised-cosine entry k of a table that covers half a turn in 2^(log2d-1) steps.
  function automatic logic [WIN_W-1:0] win_entry(input int unsigned k,
                                                 input int unsigned log2d);
    longint unsigned ang;
    longint unsigned w30;
    longint unsigned half_depth;
    half_depth = 64'd1 << (log2d - 1);
    ang = (TWO_PI_Q30 * longint'(k) + half_depth) >> log2d;
    if (ang > PI_Q30) ang = PI_Q30;
    if (ang <= HALF_PI_Q30) w30 = (ONE_Q30 + cos_quadrant(ang)) >> 1;
    else                    w30 = (ONE_Q30 - cos_quadrant(PI_Q30 - ang)) >> 1;
    return WIN_W'((w30 + 64'd16384) >> 15);
  endfunction

endpackage

`default_nettype wire

@@ rtl/twr_channels.sv @@
// Handshake channel interfaces: input request, result and register write.
// Depends on twr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface twr_in_if;
  import twr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;
  logic [GAIN_W-1:0] gain;
  modport source (output valid, freq_hz, gain, input ready);
  modport sink   (input valid, freq_hz, gain, output ready);
endinterface

interface twr_out_if #(
  parameter int SAMPLE_BITS = twr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface twr_cfg_if;
  import twr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/twr_win_rom.sv @@
// Raised-cosine window ROM, half a turn plus the end point, registered read.
// Depends on twr_pkg for the entry function and the word width.
`timescale 1ns / 1ps
`default_nettype none

module twr_win_rom #(
  parameter int COS_TABLE_DEPTH = twr_pkg::COS_TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic [$clog2(COS_TABLE_DEPTH)-1:0] addr,
  output logic [twr_pkg::WIN_W-1:0]               data
);
  import twr_pkg::*;

  localparam int LOG2_DEPTH = $clog2(COS_TABLE_DEPTH);
  localparam int TABLE_LEN  = COS_TABLE_DEPTH / 2 + 1;

  typedef logic [WIN_W-1:0] rom_t [TABLE_LEN];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int k = 0; k < TABLE_LEN; k++) begin
      tbl[k] = win_entry(k, LOG2_DEPTH);
    end
    return tbl;
  endfunction

  localparam rom_t WIN_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= WIN_ROM[addr];
  end

endmodule

`default_nettype wire

@@ rtl/tukey_window_oscillator.sv @@
// Tukey window oscillator top level: sequencer, shared multiplier and divider.
// Depends on twr_pkg, the channel interfaces and twr_win_rom.
//
// Usage: each request on in_ch is one audio tick carrying freq_hz (Q15.8 Hz)
// and gain (Q1.15). For each request one sample appears on out_ch: the
// Tukey window at the current phase, signed by the travel direction, scaled
// by gain and saturated. The phase then advances by rate_scale * freq_hz.
// cfg_ch writes taper_ratio (index 0) and rate_scale (index 1); it is always
// ready and is meant to be written between requests only.
// Timing: in_ch.ready is high only while the sequencer is idle. Inside the
// taper a request passes through ST_DIST, ST_STEP, ST_PHASE, ST_DIV, ST_ROM,
// ST_MUL and ST_FIN before out_ch.valid is set, and the next request is taken
// only once the sequencer is back in ST_IDLE; in the flat middle of the
// window ST_DIV and ST_ROM are skipped. The restoring divider that turns the
// taper distance into a table index, one quotient bit per cycle, is the
// longest part of a request inside the taper.
// The result sits in an output register: a stalled receiver does not stop
// the next request from being taken, only its final write-back waits.
// Reset (rst_n low, synchronous) restores both registers to their defaults,
// zeroes the phase and sets the positive direction.
`timescale 1ns / 1ps
`default_nettype none

module tukey_window_oscillator #(
  parameter int COS_TABLE_DEPTH = twr_pkg::COS_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS     = twr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  twr_in_if.sink      in_ch,
  twr_out_if.source   out_ch,
  twr_cfg_if.sink     cfg_ch
);
  import twr_pkg::*;

  localparam int ADDR_W = $clog2(COS_TABLE_DEPTH);
  localparam int CNT_W  = $clog2(ADDR_W);
  localparam int SH     = 31 - SAMPLE_BITS;
  localparam int P_W    = SAMPLE_BITS + 1;

  localparam logic [ADDR_W-1:0]   HALF_IDX  = ADDR_W'(COS_TABLE_DEPTH / 2);
  localparam logic [CNT_W-1:0]    CNT_LAST  = CNT_W'(ADDR_W - 1);
  localparam logic [PHASE_W-1:0]  RND       = PHASE_W'(1) << (SH - 1);
  localparam logic [P_W-1:0]      NEG_LIM   = P_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  state_t state_r, state_nxt;

  // control state
  logic [TAPER_W-1:0]     taper_r;
  logic [RATE_W-1:0]      rate_r;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic                   neg_dir_r, neg_dir_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  // payload
  logic [FREQ_W-1:0]      freq_r, freq_nxt;
  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [TAPER_W-1:0]     reff_r, reff_nxt;
  logic                   sign_r, sign_nxt;
  logic                   hit_r, hit_nxt;
  logic [PHASE_W-1:0]     rem_r, rem_nxt;
  logic [PHASE_W-1:0]     div_r, div_nxt;
  logic [ADDR_W-1:0]      quo_r, quo_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;

  // datapath nets
  logic [FREQ_W-1:0]      mul_a;
  logic [RATE_W-1:0]      mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [WIN_W-1:0]       rom_data;
  logic [WIN_W-1:0]       win;
  logic [ADDR_W-1:0]      rom_addr;
  logic [PHASE_W-1:0]     half;
  logic [PHASE_W:0]       hsum;
  logic [PHASE_W-1:0]     step;
  logic [PHASE_W:0]       psum;
  logic                   ge;
  logic [PHASE_W-1:0]     rounded;
  logic [P_W-1:0]         pmag;
  logic [P_W-1:0]         pneg;
  logic [SAMPLE_BITS-1:0] res;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  assign rom_addr = (quo_r > HALF_IDX) ? HALF_IDX : quo_r;

  twr_win_rom #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    // shared multiplier: step product in ST_STEP, window times gain otherwise
    win   = hit_r ? rom_data : WIN_ONE;
    mul_a = (state_r == ST_STEP) ? freq_r : FREQ_W'(gain_r);
    mul_b = (state_r == ST_STEP) ? rate_r : RATE_W'(win);
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    half = {reff_r, 15'd0};
    hsum = {1'b0, phase_r} + {1'b0, half};

    step = (|prod_r[PROD_W-1:PHASE_W+8]) ? {PHASE_W{1'b1}} : prod_r[PHASE_W+7:8];
    psum = {1'b0, phase_r} + {1'b0, step};

    ge = (rem_r >= div_r);

    rounded = prod_r[PHASE_W-1:0] + RND;
    pmag    = rounded[PHASE_W-1:SH];
    pneg    = (pmag > NEG_LIM) ? NEG_LIM : pmag;
    if (sign_r) begin
      res = SAMPLE_BITS'(~pneg + P_W'(1));
    end else if (pmag[P_W-1] | pmag[P_W-2]) begin
      res = POS_MAX;
    end else begin
      res = pmag[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    neg_dir_nxt    = neg_dir_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cnt_nxt        = cnt_r;
    freq_nxt       = freq_r;
    gain_nxt       = gain_r;
    reff_nxt       = reff_r;
    sign_nxt       = sign_r;
    hit_nxt        = hit_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    prod_nxt       = prod_r;
    out_sample_nxt = out_sample_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          freq_nxt = in_ch.freq_hz;
          gain_nxt = in_ch.gain;
          sign_nxt = neg_dir_r;
          if (taper_r[TAPER_W-1])  reff_nxt = TAPER_ONE;
          else if (taper_r == '0)  reff_nxt = TAPER_W'(1);
          else                     reff_nxt = taper_r;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        // distance into the rising or the falling taper, or the flat middle
        if (phase_r <= half) begin
          hit_nxt = 1'b1;
          rem_nxt = half - phase_r;
        end else if (!hsum[PHASE_W]) begin
          hit_nxt = 1'b0;
          rem_nxt = '0;
        end else begin
          hit_nxt = 1'b1;
          rem_nxt = hsum[PHASE_W-1:0];
        end
        div_nxt   = half;
        quo_nxt   = '0;
        cnt_nxt   = CNT_LAST;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        prod_nxt  = mul_p;
        state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        // flip direction only when the sum passes one, not when it hits it
        if (psum[PHASE_W] && (|psum[PHASE_W-1:0])) neg_dir_nxt = ~neg_dir_r;
        phase_nxt = psum[PHASE_W-1:0];
        state_nxt = hit_r ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (ge) rem_nxt = rem_r - div_r;
        quo_nxt = {quo_r[ADDR_W-2:0], ge};
        div_nxt = div_r >> 1;
        if (cnt_r == '0) begin
          state_nxt = ST_ROM;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_ROM: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_sample_nxt = res;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taper_r     <= TAPER_RESET;
      rate_r      <= RATE_RESET;
      phase_r     <= '0;
      neg_dir_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      neg_dir_r   <= neg_dir_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_TAPER_RATIO: taper_r <= cfg_ch.data[TAPER_W-1:0];
          REG_RATE_SCALE:  rate_r  <= cfg_ch.data[RATE_W-1:0];
          default: begin
            // drop writes to unknown registers
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    freq_r       <= freq_nxt;
    gain_r       <= gain_nxt;
    reff_r       <= reff_nxt;
    sign_r       <= sign_nxt;
    hit_r        <= hit_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    quo_r        <= quo_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_DIST)
    else $error("accepted request did not start the sequence");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> {1'b0, rem_r} < {div_r, 1'b0})
    else $error("divider remainder out of range");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROM |-> quo_r <= HALF_IDX)
    else $error("window index beyond half a turn");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_PHASE |=> $stable(phase_r))
    else $error("phase moved outside the update step");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside the final step");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for tukey_window_oscillator: directed plan, then random ticks.
// Depends on twr_pkg, the twr channel interfaces and the oscillator RTL.
`timescale 1ns / 1ps

module tb_top;
  import twr_pkg::*;

  localparam int SMP_W          = SAMPLE_BITS_DEF;
  localparam int LUT_DEPTH      = COS_TABLE_DEPTH_DEF;
  localparam int LUT_LAST       = LUT_DEPTH / 2;
  localparam int ROUND_SH       = 31 - SMP_W;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 12;
  localparam int TICKS_PER_SET  = 138;
  localparam longint unsigned PHASE_ONE = 64'h1_0000_0000;
  localparam longint unsigned SMP_MAX   = (64'd1 << (SMP_W - 1)) - 1;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 4'd9;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_WRITE
  } row_kind_t;

  // For ROW_WRITE, idx and arg carry the register index and data.
  typedef struct packed {
    row_kind_t          kind;
    logic [3:0]         idx;
    logic [22:0]        arg;
    logic [15:0]        gain;
    logic               known;
    logic signed [15:0] sample;
  } row_t;

  localparam int PLAN_LEN = 32;
  localparam row_t PLAN [0:PLAN_LEN-1] = '{
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32768, 1'b1,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd65535, 1'b1,  16'sd0},
    '{ROW_WRITE, REG_RATE_SCALE,  23'h100000, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h080000, 16'd32768, 1'b1,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32768, 1'b1,  16'sd32767},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd65535, 1'b1,  16'sd32767},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd0,     1'b1,  16'sd0},
    // phase lands exactly on one: wrap without a flip
    '{ROW_TICK,  4'd0,            23'h080000, 16'd16384, 1'b1,  16'sd16384},
    '{ROW_TICK,  4'd0,            23'h080000, 16'd32768, 1'b1,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h080001, 16'd16384, 1'b1,  16'sd16384},
    '{ROW_TICK,  4'd0,            23'h07FFFF, 16'd16384, 1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32768, 1'b1, -16'sd32768},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd65535, 1'b1, -16'sd32768},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd1,     1'b1, -16'sd1},
    '{ROW_WRITE, REG_RATE_SCALE,  23'h1FFFFF, 16'd0,     1'b0,  16'sd0},
    // step saturates just below one turn
    '{ROW_TICK,  4'd0,            23'h7FFFFF, 16'd16384, 1'b1, -16'sd16384},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32767, 1'b1,  16'sd32767},
    '{ROW_WRITE, REG_RATE_SCALE,  23'h000000, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h7FFFFF, 16'd32767, 1'b1,  16'sd32767},
    '{ROW_TICK,  4'd0,            23'd6144000, 16'd8192, 1'b1,  16'sd8192},
    '{ROW_WRITE, REG_TAPER_RATIO, 23'h000000, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32767, 1'b1,  16'sd32767},
    '{ROW_WRITE, REG_RATE_SCALE,  23'h100000, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h080000, 16'd32767, 1'b1,  16'sd32767},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32768, 1'b0,  16'sd0},
    '{ROW_WRITE, REG_TAPER_RATIO, 23'h01FFFF, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd40000, 1'b0,  16'sd0},
    '{ROW_WRITE, IDX_SPARE,       23'h00ABCD, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h012345, 16'h8000,  1'b0,  16'sd0},
    // bits above the taper field are dropped, leaving zero taper
    '{ROW_WRITE, REG_TAPER_RATIO, 23'h1E0000, 16'd0,     1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h000000, 16'd32768, 1'b0,  16'sd0},
    '{ROW_TICK,  4'd0,            23'h400000, 16'hFFFF,  1'b0,  16'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  twr_in_if                        in_ch ();
  twr_out_if #(.SAMPLE_BITS(SMP_W)) out_ch ();
  twr_cfg_if                       cfg_ch ();

  tukey_window_oscillator #(
    .COS_TABLE_DEPTH(LUT_DEPTH),
    .SAMPLE_BITS    (SMP_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block's registers and state.
  logic [WIN_W-1:0]   win_lut [0:LUT_LAST];
  logic [TAPER_W-1:0] taper_q16;
  logic [RATE_W-1:0]  rate_q32;
  logic [PHASE_W-1:0] phase_q32;
  logic               dir_neg;

  logic signed [SMP_W-1:0] expected_samples [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int tick_count;
  int check_count;
  int write_count;
  int flip_count;
  int quiet_cycles;

  // cos(y), y in [0, pi/2], Q2.30, Taylor series through the y^20 term, clamped to [0, 1.0].
  function automatic longint cos_taylor_q30(input longint unsigned y);
    longint unsigned y2;
    longint unsigned term;
    longint unsigned prod;
    longint          acc;
    int              n;
    y2   = (y * y) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (n = 1; n <= 10; n++) begin
      prod = (term * y2) >> 30;
      term = prod / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
    return acc;
  endfunction

  function automatic void build_win_lut();
    longint unsigned ang;
    longint unsigned w30;
    int              k;
    for (k = 0; k <= LUT_LAST; k++) begin
      ang = (TWO_PI_Q30 * longint'(k) + longint'(LUT_DEPTH / 2)) / longint'(LUT_DEPTH);
      if (ang > PI_Q30) ang = PI_Q30;
      if (ang <= HALF_PI_Q30) w30 = (ONE_Q30 + cos_taylor_q30(ang)) >> 1;
      else                    w30 = (ONE_Q30 - cos_taylor_q30(PI_Q30 - ang)) >> 1;
      win_lut[k] = WIN_W'((w30 + 64'd16384) >> 15);
    end
  endfunction

  // Sample for the current phase, then advance phase and direction.
  function automatic logic signed [SMP_W-1:0] next_sample(input logic [FREQ_W-1:0] f,
                                                          input logic [GAIN_W-1:0] g);
    longint unsigned r;
    longint unsigned half;
    longint unsigned gap;
    longint unsigned turns;
    longint unsigned idx;
    longint unsigned w;
    longint unsigned p;
    longint unsigned step;
    longint unsigned total;
    logic            in_taper;
    logic [SMP_W-1:0] res;
    r = longint'(taper_q16);
    if (r == 0) r = 1;
    if (r > longint'(TAPER_ONE)) r = longint'(TAPER_ONE);
    half     = r << 15;
    in_taper = 1'b1;
    gap      = 0;
    if (longint'(phase_q32) <= half) gap = half - longint'(phase_q32);
    else if (longint'(phase_q32) < PHASE_ONE - half) in_taper = 1'b0;
    else gap = longint'(phase_q32) - (PHASE_ONE - half);
    if (in_taper) begin
      turns = (gap << 16) / r;
      idx   = (turns * longint'(LUT_DEPTH)) >> 32;
      if (idx > LUT_LAST) idx = LUT_LAST;
      w = longint'(win_lut[idx]);
    end else begin
      w = longint'(WIN_ONE);
    end
    p = (w * longint'(g) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    if (dir_neg) begin
      if (p > SMP_MAX + 1) p = SMP_MAX + 1;
      res = SMP_W'(64'd0 - p);
    end else begin
      if (p > SMP_MAX) p = SMP_MAX;
      res = SMP_W'(p);
    end
    step = (64'(rate_q32) * 64'(f)) >> 8;
    if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
    total = 64'(phase_q32) + step;
    if (total > PHASE_ONE) begin
      dir_neg    = ~dir_neg;
      flip_count = flip_count + 1;
    end
    phase_q32 = total[PHASE_W-1:0];
    return res;
  endfunction

  // Send one tick; typed value overrides the prediction when given.
  task automatic push_tick(input logic [FREQ_W-1:0] f, input logic [GAIN_W-1:0] g,
                           input logic known, input logic signed [SMP_W-1:0] typed);
    logic signed [SMP_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.freq_hz <= f;
    in_ch.gain    <= g;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_sample(f, g);
    expected_samples.push_back(known ? typed : predicted);
    tick_count = tick_count + 1;
  endtask

  // Register write once the block has drained and gone quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TAPER_RATIO)     taper_q16 = data[TAPER_W-1:0];
    else if (idx == REG_RATE_SCALE) rate_q32  = data[RATE_W-1:0];
    write_count = write_count + 1;
  endtask

  // Result side: check, randomize ready, watch for a hang.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample %0d with no tick pending", $time, out_ch.sample);
        error_count <= error_count + 1;
      end else begin
        if (out_ch.sample !== expected_samples[0]) begin
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, expected_samples[0], out_ch.sample);
          error_count <= error_count + 1;
        end
        void'(expected_samples.pop_front());
        check_count <= check_count + 1;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d samples outstanding",
                 $time, quiet_cycles, expected_samples.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [TAPER_W-1:0]    taper_val;
    logic [CFG_DATA_W-1:0] rate_val;
    logic [FREQ_W-1:0]     f;
    logic [GAIN_W-1:0]     g;
    int                    ph;
    int                    i;
    int                    rand_done;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.freq_hz = '0;
    in_ch.gain    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    error_count   = 0;
    tick_count    = 0;
    check_count   = 0;
    write_count   = 0;
    flip_count    = 0;
    quiet_cycles  = 0;
    rand_done     = 0;
    send_idle_pct = 16;
    recv_idle_pct = 69;
    build_win_lut();
    taper_q16 = TAPER_RESET;
    rate_q32  = RATE_RESET;
    phase_q32 = '0;
    dir_neg   = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE)
        write_reg(PLAN[i].idx, PLAN[i].arg[CFG_DATA_W-1:0]);
      else
        push_tick(PLAN[i].arg, PLAN[i].gain, PLAN[i].known, PLAN[i].sample);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          taper_val = 17'd1;
          rate_val  = 21'd44739;
        end
        1: begin
          taper_val = TAPER_ONE;
          rate_val  = 21'd1073742;
        end
        2: begin
          taper_val = '0;
          rate_val  = CFG_DATA_W'($urandom_range(44739, 1073742));
        end
        3: begin
          taper_val = '1;
          rate_val  = '1;
        end
        4: begin
          taper_val = TAPER_RESET;
          rate_val  = CFG_DATA_W'(RATE_RESET);
        end
        default: begin
          taper_val = TAPER_W'($urandom_range(1, 65536));
          if ($urandom_range(3) == 0) rate_val = CFG_DATA_W'($urandom);
          else                        rate_val = CFG_DATA_W'($urandom_range(44739, 1073742));
        end
      endcase
      write_reg(REG_TAPER_RATIO, CFG_DATA_W'(taper_val));
      write_reg(REG_RATE_SCALE, rate_val);
      write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));

      for (i = 0; i < TICKS_PER_SET; i++) begin
        if (rand_done < 550) begin
          send_idle_pct = 16;
          recv_idle_pct = 69;
        end else if (rand_done < 1100) begin
          send_idle_pct = 69;
          recv_idle_pct = 16;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        case ($urandom_range(9))
          0:       f = '0;
          1:       f = FREQ_W'($urandom);
          2:       f = FREQ_W'($urandom_range(5000000, 6144000));
          3, 4, 5, 6: f = FREQ_W'($urandom_range(256 * 20, 256 * 2000));
          default: f = FREQ_W'($urandom_range(0, 6144000));
        endcase
        case ($urandom_range(7))
          0:       g = (($urandom_range(1) == 0) ? '0 : '1);
          1:       g = 16'd32768;
          2:       g = GAIN_W'($urandom);
          default: g = GAIN_W'($urandom_range(0, 32768));
        endcase
        push_tick(f, g, 1'b0, '0);
        rand_done = rand_done + 1;
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d ticks, %0d samples checked, %0d register writes, %0d errors",
             tick_count, check_count, write_count, error_count);
    $display("%0d direction flips over %0d taper/rate settings and three idle profiles",
             flip_count, RAND_PHASES);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/twr_pkg.sv
rtl/twr_channels.sv
rtl/twr_win_rom.sv
rtl/tukey_window_oscillator.sv
sim/tb_top.sv
